// ----- rtl/lru_stack_reuse_distance_macros.svh -----
// Assertion macros shared by the reuse-distance tracker.
`ifndef LRU_STACK_REUSE_DISTANCE_MACROS_SVH
`define LRU_STACK_REUSE_DISTANCE_MACROS_SVH

// Checks that a condition implies another in the same cycle.
`define LRSD_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("lrsd check failed");

// Checks that a condition implies another in the next cycle.
`define LRSD_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("lrsd check failed");

`endif

// ----- rtl/lrsd_pkg.sv -----
// Package with the types and constants of the reuse-distance tracker.
package lrsd_pkg;

   localparam int ADDR_W     = 48;
   localparam int PAGE_SHIFT = 12;
   localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
   localparam int DIST_W     = 8;
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
   localparam int GROUP_SIZE = 16;

   typedef logic [PAGE_W-1:0] page_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_REDUCE,
      ST_RESOLVE,
      ST_UPDATE
   } state_type;

   // Control broadcast from the sequencer to every cell of the stack.
   typedef struct packed {
      logic match_en;
      logic update_en;
      logic hit;
   } cell_ctrl_type;

endpackage

// ----- rtl/lru_stack_reuse_distance.sv -----
// Top level of the LRU stack reuse-distance tracker.
// Each request beat carries one physical byte address; its page number (bits 47:12) is looked
// up in a stack of WINDOW_DEPTH cells, top first, and one response beat comes back per request.
// On a hit the response gives the page's old stack position, saturated at 255, and the page
// moves to the top while the entries above it move down one cell; on a miss the response has
// hit low and distance zero, every entry moves down, the bottom one falls off and the page is
// placed on top. Page zero is an ordinary page: only the per-cell valid bits mark empty entries,
// and reset clears them all at once, so no clearing pass is needed. One request is in flight at
// a time, and a request passes through these steps before the next one is accepted: the page is
// registered, every cell compares it in parallel, the one-hot match flags are encoded in groups
// of sixteen and then across groups, and finally every cell shifts together. The response sits in
// an output register, so a new request is taken while an earlier response still waits; the
// shift cycle is only held back if that register is still full.
module lru_stack_reuse_distance
   import lrsd_pkg::*;
#(
   parameter int WINDOW_DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [ADDR_W-1:0]  req_phys_addr,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit,
   output logic [DIST_W-1:0]  rsp_distance
);

`include "lru_stack_reuse_distance_macros.svh"

   localparam int IDX_W      = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int NUM_GROUPS = (WINDOW_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int POS_W      = (IDX_W > DIST_W) ? IDX_W : DIST_W;

   state_type state_ff, state_in;

   page_type         page_ff;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] pos_ff, pos_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff;
   logic [DIST_W-1:0] rsp_distance_ff;
   logic [DIST_W-1:0] distance_sat;
   logic [POS_W-1:0]  pos_wide;

   logic          accept;
   logic          group_en;
   logic          resolve_en;
   cell_ctrl_type ctrl;

   page_type          chain_page  [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0] chain_valid;
   logic [WINDOW_DEPTH-1:0] match_vec;

   logic             grp_any [NUM_GROUPS];
   logic [IDX_W-1:0] grp_idx [NUM_GROUPS];

   // Sequencer: next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_MATCH;
         ST_MATCH:   state_in = ST_REDUCE;
         ST_REDUCE:  state_in = ST_RESOLVE;
         ST_RESOLVE: state_in = ST_UPDATE;
         ST_UPDATE:  if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Sequencer: outputs.
   always_comb begin
      req_ready      = (state_ff == ST_IDLE);
      group_en       = (state_ff == ST_REDUCE);
      resolve_en     = (state_ff == ST_RESOLVE);
      ctrl.match_en  = (state_ff == ST_MATCH);
      ctrl.update_en = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ready);
      ctrl.hit       = hit_ff;
   end

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         page_ff <= req_phys_addr[ADDR_W-1:PAGE_SHIFT];
      end
   end

   // The stack itself: cell 0 is the top and takes the new page when the stack shifts.
   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      page_type up_page;
      logic     up_valid;
      if (i == 0) begin : g_top
         assign up_page  = page_ff;
         assign up_valid = 1'b1;
      end else begin : g_rest
         assign up_page  = chain_page[i-1];
         assign up_valid = chain_valid[i-1];
      end
      lrsd_cell #(
         .IDX   (i),
         .IDX_W (IDX_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .req_page (page_ff),
         .hit_pos  (pos_ff),
         .up_page  (up_page),
         .up_valid (up_valid),
         .page     (chain_page[i]),
         .valid    (chain_valid[i]),
         .match    (match_vec[i])
      );
   end

   // First level of the match encoder, one group of cells each.
   for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
      localparam int BASE = g * GROUP_SIZE;
      localparam int CNT  = (WINDOW_DEPTH - BASE > GROUP_SIZE) ? GROUP_SIZE
                                                                : WINDOW_DEPTH - BASE;
      lrsd_group_reduce #(
         .IDX_W (IDX_W),
         .BASE  (BASE),
         .COUNT (CNT)
      ) u_group (
         .clock  (clock),
         .enable (group_en),
         .match  (match_vec[BASE +: CNT]),
         .any    (grp_any[g]),
         .idx    (grp_idx[g])
      );
   end

   // Second level: combine the groups into the hit flag and the stack position.
   always_comb begin
      hit_in = 1'b0;
      pos_in = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         hit_in = hit_in | grp_any[g];
         pos_in = pos_in | (grp_any[g] ? grp_idx[g] : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (resolve_en) begin
         hit_ff <= hit_in;
      end
      if (resolve_en) begin
         pos_ff <= pos_in;
      end
   end

   // Distance saturates for stacks deeper than the result field can express.
   always_comb begin
      pos_wide     = POS_W'(pos_ff);
      distance_sat = (pos_wide > POS_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(pos_wide);
   end

   // Response register: filled in the shift cycle, emptied when the beat is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.update_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (ctrl.update_en) begin
         rsp_hit_ff      <= hit_ff;
         rsp_distance_ff <= hit_ff ? distance_sat : '0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_distance = rsp_distance_ff;

   // A page is held in the stack at most once, so no more than one cell can match.
   `LRSD_ASSERT_NOW(a_single_match, clock, reset, state_ff == ST_REDUCE, $onehot0(match_vec))
   // Valid entries always form an unbroken run from the top of the stack.
   `LRSD_ASSERT_NOW(a_valid_run, clock, reset, 1'b1,
                    ((chain_valid + WINDOW_DEPTH'(1)) & chain_valid) == '0)
   // The shift cycle always puts a valid entry on top.
   `LRSD_ASSERT_NEXT(a_top_filled, clock, reset, ctrl.update_en, chain_valid[0])
   // A miss always reports distance zero.
   `LRSD_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid_ff && !rsp_hit_ff,
                    rsp_distance_ff == '0)

endmodule

// ----- rtl/lrsd_cell.sv -----
// One entry of the LRU stack: page register, valid bit and match flag.
module lrsd_cell
   import lrsd_pkg::*;
#(
   parameter int IDX   = 0,
   parameter int IDX_W = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  cell_ctrl_type      ctrl,
   input  page_type           req_page,
   input  logic [IDX_W-1:0]   hit_pos,
   input  page_type           up_page,
   input  logic               up_valid,
   output page_type           page,
   output logic               valid,
   output logic               match
);

   page_type page_ff, page_in;
   logic     valid_ff, valid_in;
   logic     match_ff, match_in;
   logic     shift;

   // An entry moves down on a miss, or on a hit at or below its own position.
   always_comb begin
      shift    = ctrl.update_en && (!ctrl.hit || (IDX_W'(IDX) <= hit_pos));
      page_in  = shift ? up_page  : page_ff;
      valid_in = shift ? up_valid : valid_ff;
      match_in = ctrl.match_en ? (valid_ff && (page_ff == req_page)) : match_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
      page_ff <= page_in;
   end

   assign page  = page_ff;
   assign valid = valid_ff;
   assign match = match_ff;

endmodule

// ----- rtl/lrsd_group_reduce.sv -----
// Registered encoder that turns the match flags of one group of cells into an index.
module lrsd_group_reduce
   import lrsd_pkg::*;
#(
   parameter int IDX_W = 8,
   parameter int BASE  = 0,
   parameter int COUNT = 16
) (
   input  logic               clock,
   input  logic               enable,
   input  logic [COUNT-1:0]   match,
   output logic               any,
   output logic [IDX_W-1:0]   idx
);

   logic             any_ff, any_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   // At most one entry matches, so an OR of the masked indices encodes it.
   always_comb begin
      any_in = 1'b0;
      idx_in = '0;
      for (int k = 0; k < COUNT; k++) begin
         any_in = any_in | match[k];
         idx_in = idx_in | (match[k] ? IDX_W'(BASE + k) : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         any_ff <= any_in;
         idx_ff <= idx_in;
      end
   end

   assign any = any_ff;
   assign idx = idx_ff;

endmodule
